// ----- rtl/crosspoint_relay_matrix_controller_assert.svh -----
// ----------------------------------------------------------------------------
// Crosspoint relay matrix controller assertion macros
// Concurrent assertion shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef CROSSPOINT_RELAY_MATRIX_CONTROLLER_ASSERT_SVH
`define CROSSPOINT_RELAY_MATRIX_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define CRMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CRMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/crmc_pkg.sv -----
// ----------------------------------------------------------------------------
// Crosspoint relay matrix controller package
// Function and status codes shared by the controller and its checker.
// ----------------------------------------------------------------------------
package crmc_pkg;

    localparam int FIELD_W  = 4;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int DRIVE_W  = 16;

    localparam logic [FUNC_W-1:0] FN_CLOSE        = 3'd0;
    localparam logic [FUNC_W-1:0] FN_OPEN         = 3'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY_CLOSED = 3'd2;
    localparam logic [FUNC_W-1:0] FN_QUERY_OPEN   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_OPEN_ALL     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LIST     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd2;

endpackage

// ----- rtl/crmc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module crmc_ram
#(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/crosspoint_relay_matrix_controller.sv -----
// ----------------------------------------------------------------------------
// Crosspoint relay matrix controller
// Expands channel-list entries into a list buffer and carries out close,
// open, query and open-all commands on a ROWS x COLS crosspoint map.
//
//   Channel   Direction  Handshake        Fields
//   entry     in         start / busy     func row_from col_from row_to
//                                         col_to ranged has_column last
//   result    out        done (strobe)    status state_bit relay_drive last_res
//
// Each entry adds its channels to the list buffer, one list write a cycle.
// After a last entry, open-all and errors finish in the dispatch state; open
// and close gather the list first, close then checking exclusivity one row or
// column a cycle; queries give one result a cycle once list read data arrives.
// Reset clears the map, the list count and the error flag; busy is low after.
// Results are shown for one cycle each and cannot be held off.
// ----------------------------------------------------------------------------
module crosspoint_relay_matrix_controller
    import crmc_pkg::*;
#(
    parameter int ROWS       = 4,
    parameter int COLS       = 4,
    parameter int LIST_DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [FIELD_W-1:0]  row_from,
    input  logic [FIELD_W-1:0]  col_from,
    input  logic [FIELD_W-1:0]  row_to,
    input  logic [FIELD_W-1:0]  col_to,
    input  logic                ranged,
    input  logic                has_column,
    input  logic                last,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic                state_bit,
    output logic [DRIVE_W-1:0]  relay_drive,
    output logic                last_res
);

    localparam int MAP_W = ROWS * COLS;
    localparam int CH_W  = $clog2(MAP_W);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int AW    = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int LW    = (ROWS > COLS) ? ROWS : COLS;
    localparam int CK_W  = $clog2(ROWS + COLS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPAND,
        S_DISPATCH,
        S_GATHER,
        S_CHECK,
        S_QUERY
    } state_t;

    state_t              state_reg, state_next;
    logic [MAP_W-1:0]    map_reg, map_next;
    logic [MAP_W-1:0]    listed_reg, listed_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                err_reg, err_next;
    logic                pend_reg, pend_next;
    logic                conflict_reg, conflict_next;
    logic [CK_W-1:0]     ck_reg, ck_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [RW-1:0]       rend_reg, rend_next;
    logic                rup_reg, rup_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [CW-1:0]       cstart_reg, cstart_next;
    logic [CW-1:0]       cend_reg, cend_next;
    logic                cup_reg, cup_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic                elast_reg, elast_next;
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                bit_reg, bit_next;
    logic [DRIVE_W-1:0]  drive_reg, drive_next;
    logic                lres_reg, lres_next;

    logic [FIELD_W-1:0]  r0, r1, c0, c1;
    logic                idx_err;
    logic                ram_we, ram_re;
    logic [CH_W-1:0]     ram_wdata, ram_rdata;
    logic [MAP_W-1:0]    staged;
    logic [LW-1:0]       line_bits;
    logic                line_multi;

    function automatic logic [DRIVE_W-1:0] to_drive(input logic [MAP_W-1:0] m);
        logic [63:0] ext;
        ext = 64'(m);
        return ext[DRIVE_W-1:0];
    endfunction

    crmc_ram #(
        .WIDTH (CH_W),
        .DEPTH (LIST_DEPTH)
    ) u_list (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        r0 = row_from;
        r1 = ranged ? row_to : row_from;
        c0 = has_column ? col_from : '0;
        c1 = has_column ? (ranged ? col_to : col_from) : '0;
        idx_err = (r0 >= FIELD_W'(ROWS)) || (r1 >= FIELD_W'(ROWS)) ||
                  (c0 >= FIELD_W'(COLS)) || (c1 >= FIELD_W'(COLS));
    end

    assign ram_wdata = CH_W'(int'(row_reg) * COLS + int'(col_reg));
    assign staged    = map_reg | listed_reg;

    always_comb
    begin
        line_bits = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            for (int j = 0; j < COLS; j++)
            begin
                if (ck_reg == CK_W'(i))
                begin
                    line_bits[j] = line_bits[j] | staged[i * COLS + j];
                end
                if (ck_reg == CK_W'(ROWS + j))
                begin
                    line_bits[i] = line_bits[i] | staged[i * COLS + j];
                end
            end
        end
        line_multi = |(line_bits & (line_bits - LW'(1)));
    end

    always_comb
    begin
        state_next    = state_reg;
        map_next      = map_reg;
        listed_next   = listed_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        err_next      = err_reg;
        pend_next     = pend_reg;
        conflict_next = conflict_reg;
        ck_next       = ck_reg;
        row_next      = row_reg;
        rend_next     = rend_reg;
        rup_next      = rup_reg;
        col_next      = col_reg;
        cstart_next   = cstart_reg;
        cend_next     = cend_reg;
        cup_next      = cup_reg;
        func_next     = func_reg;
        elast_next    = elast_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        bit_next      = bit_reg;
        drive_next    = drive_reg;
        lres_next     = lres_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next   = func;
                    elast_next  = last;
                    row_next    = RW'(r0);
                    rend_next   = RW'(r1);
                    rup_next    = r0 < r1;
                    col_next    = CW'(c0);
                    cstart_next = CW'(c0);
                    cend_next   = CW'(c1);
                    cup_next    = c0 < c1;
                    priority if (err_reg)
                    begin
                        state_next = last ? S_DISPATCH : S_IDLE;
                    end
                    else if (idx_err)
                    begin
                        err_next   = 1'b1;
                        state_next = last ? S_DISPATCH : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EXPAND;
                    end
                end
            end

            S_EXPAND:
            begin
                if (count_reg == CNT_W'(LIST_DEPTH))
                begin
                    err_next   = 1'b1;
                    state_next = elast_reg ? S_DISPATCH : S_IDLE;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (col_reg == cend_reg)
                    begin
                        if (row_reg == rend_reg)
                        begin
                            state_next = elast_reg ? S_DISPATCH : S_IDLE;
                        end
                        else
                        begin
                            row_next = rup_reg ? row_reg + RW'(1) : row_reg - RW'(1);
                            col_next = cstart_reg;
                        end
                    end
                    else
                    begin
                        col_next = cup_reg ? col_reg + CW'(1) : col_reg - CW'(1);
                    end
                end
            end

            S_DISPATCH:
            begin
                idx_next    = '0;
                pend_next   = 1'b0;
                listed_next = '0;
                priority if (func_reg == FN_OPEN_ALL)
                begin
                    map_next    = '0;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    bit_next    = 1'b0;
                    drive_next  = '0;
                    lres_next   = 1'b1;
                    count_next  = '0;
                    err_next    = 1'b0;
                    state_next  = S_IDLE;
                end
                else if (func_reg > FN_OPEN_ALL || err_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_LIST;
                    bit_next    = 1'b0;
                    drive_next  = to_drive(map_reg);
                    lres_next   = 1'b1;
                    count_next  = '0;
                    err_next    = 1'b0;
                    state_next  = S_IDLE;
                end
                else if (func_reg == FN_CLOSE || func_reg == FN_OPEN)
                begin
                    state_next = S_GATHER;
                end
                else if (count_reg == '0)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    bit_next    = 1'b0;
                    drive_next  = to_drive(map_reg);
                    lres_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_QUERY;
                end
            end

            S_GATHER:
            begin
                if (pend_reg)
                begin
                    listed_next = listed_reg | (MAP_W'(1) << ram_rdata);
                end
                if (idx_reg < count_reg)
                begin
                    ram_re    = 1'b1;
                    idx_next  = idx_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (func_reg == FN_CLOSE)
                        begin
                            ck_next       = '0;
                            conflict_next = 1'b0;
                            state_next    = S_CHECK;
                        end
                        else
                        begin
                            map_next    = map_reg & ~listed_reg;
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            bit_next    = 1'b0;
                            drive_next  = to_drive(map_reg & ~listed_reg);
                            lres_next   = 1'b1;
                            count_next  = '0;
                            state_next  = S_IDLE;
                        end
                    end
                end
            end

            S_CHECK:
            begin
                conflict_next = conflict_reg | line_multi;
                ck_next       = ck_reg + CK_W'(1);
                if (ck_reg == CK_W'(ROWS + COLS - 1))
                begin
                    done_next  = 1'b1;
                    bit_next   = 1'b0;
                    lres_next  = 1'b1;
                    count_next = '0;
                    state_next = S_IDLE;
                    if (conflict_reg || line_multi)
                    begin
                        status_next = ST_CONFLICT;
                        drive_next  = to_drive(map_reg);
                    end
                    else
                    begin
                        map_next    = staged;
                        status_next = ST_OK;
                        drive_next  = to_drive(staged);
                    end
                end
            end

            S_QUERY:
            begin
                if (pend_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    bit_next    = map_reg[ram_rdata] ^ (func_reg == FN_QUERY_OPEN);
                    drive_next  = to_drive(map_reg);
                    lres_next   = idx_reg == count_reg;
                end
                if (idx_reg < count_reg)
                begin
                    ram_re    = 1'b1;
                    idx_next  = idx_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (pend_reg)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            map_reg   <= '0;
            count_reg <= '0;
            err_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            map_reg   <= map_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        listed_reg   <= listed_next;
        idx_reg      <= idx_next;
        conflict_reg <= conflict_next;
        ck_reg       <= ck_next;
        row_reg      <= row_next;
        rend_reg     <= rend_next;
        rup_reg      <= rup_next;
        col_reg      <= col_next;
        cstart_reg   <= cstart_next;
        cend_reg     <= cend_next;
        cup_reg      <= cup_next;
        func_reg     <= func_next;
        elast_reg    <= elast_next;
        status_reg   <= status_next;
        bit_reg      <= bit_next;
        drive_reg    <= drive_next;
        lres_reg     <= lres_next;
    end

    assign busy        = state_reg != S_IDLE;
    assign done        = done_reg;
    assign status      = status_reg;
    assign state_bit   = bit_reg;
    assign relay_drive = drive_reg;
    assign last_res    = lres_reg;

endmodule

// ----- rtl/crmc_checker.sv -----
// ----------------------------------------------------------------------------
// Crosspoint relay matrix controller port checker
// Watches the top-level ports for command and result sequencing slips.
// ----------------------------------------------------------------------------
`include "crosspoint_relay_matrix_controller_assert.svh"

module crmc_checker
    import crmc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                last,
    input logic                done,
    input logic [STATUS_W-1:0] status,
    input logic                state_bit,
    input logic [DRIVE_W-1:0]  relay_drive,
    input logic                last_res
);

    `CRMC_ASSERT_NEXT(a_accept_busy, start && !busy && last, busy, "idle after last entry")
    `CRMC_ASSERT_NOW(a_error_final, done && status != ST_OK, last_res, "error result not final")
    `CRMC_ASSERT_NOW(a_bit_ok, done && state_bit, status == ST_OK, "state bit on error result")
    `CRMC_ASSERT_NEXT(a_burst, done && !last_res, done && $stable(relay_drive), "burst broken")
    `CRMC_ASSERT_NOW(a_partial_busy, done && !last_res, busy, "idle before final result")

endmodule

bind crosspoint_relay_matrix_controller crmc_checker u_crmc_checker (.*);

// ----- dv/crosspoint_relay_matrix_controller_checker.sv -----
// ----------------------------------------------------------------------------
// Crosspoint relay matrix controller checker
// Watches the entry and result channels of the controller, keeps its own copy
// of the crosspoint map and channel list, predicts the results of every
// accepted entry and compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module crosspoint_relay_matrix_controller_checker
    import crmc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [FIELD_W-1:0]  row_from,
    input  logic [FIELD_W-1:0]  col_from,
    input  logic [FIELD_W-1:0]  row_to,
    input  logic [FIELD_W-1:0]  col_to,
    input  logic                ranged,
    input  logic                has_column,
    input  logic                last,
    input  logic                done,
    input  logic [STATUS_W-1:0] status,
    input  logic                state_bit,
    input  logic [DRIVE_W-1:0]  relay_drive,
    input  logic                last_res,
    output int                  fail_count,
    output int                  pending,
    output int                  checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS       = 4;
    localparam int COLS       = 4;
    localparam int LIST_DEPTH = 16;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                state_bit;
        logic [DRIVE_W-1:0]  drive;
        logic                fin;
    } reply_t;

    reply_t             reply_q[$];
    logic [DRIVE_W-1:0] closed_map;
    logic [3:0]         chan_buf [LIST_DEPTH];
    int                 chan_cnt;
    bit                 chan_fault;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        closed_map = '0;
        chan_cnt   = 0;
        chan_fault = 0;
    end

    function automatic bit one_per_line(logic [DRIVE_W-1:0] m);
        int n;
        for (int j = 0; j < COLS; j++)
        begin
            n = 0;
            for (int i = 0; i < ROWS; i++)
                n += m[i*COLS+j];
            if (n > 1)
                return 0;
        end
        for (int i = 0; i < ROWS; i++)
        begin
            n = 0;
            for (int j = 0; j < COLS; j++)
                n += m[i*COLS+j];
            if (n > 1)
                return 0;
        end
        return 1;
    endfunction

    task automatic add_channel(int r, int c);
        if (chan_fault)
            return;
        if (chan_cnt >= LIST_DEPTH)
        begin
            chan_fault = 1;
            return;
        end
        chan_buf[chan_cnt] = 4'(r * COLS + c);
        chan_cnt++;
    endtask

    task automatic expand_entry();
        int r0, c0, r1, c1, r, c;
        if (chan_fault)
            return;
        r0 = row_from;
        c0 = col_from;
        r1 = ranged ? int'(row_to) : r0;
        c1 = ranged ? int'(col_to) : c0;
        if (!has_column)
        begin
            c0 = 0;
            c1 = 0;
        end
        if (r0 >= ROWS || r1 >= ROWS || c0 >= COLS || c1 >= COLS)
        begin
            chan_fault = 1;
            return;
        end
        r = r0;
        while (1)
        begin
            c = c0;
            while (1)
            begin
                add_channel(r, c);
                if (chan_fault || c == c1)
                    break;
                c = (c0 < c1) ? c + 1 : c - 1;
            end
            if (chan_fault || r == r1)
                break;
            r = (r0 < r1) ? r + 1 : r - 1;
        end
    endtask

    task automatic push_reply(logic [STATUS_W-1:0] st, logic b, logic fin);
        reply_t rep;
        rep.status    = st;
        rep.state_bit = b;
        rep.drive     = closed_map;
        rep.fin       = fin;
        reply_q.push_back(rep);
    endtask

    task automatic apply_entry();
        logic [DRIVE_W-1:0] listed;
        logic               hit;
        expand_entry();
        if (!last)
            return;
        listed = '0;
        for (int i = 0; i < chan_cnt; i++)
            listed[chan_buf[i]] = 1'b1;
        if (func == FN_OPEN_ALL)
        begin
            closed_map = '0;
            push_reply(ST_OK, 1'b0, 1'b1);
        end
        else if (func > FN_OPEN_ALL || chan_fault)
            push_reply(ST_LIST, 1'b0, 1'b1);
        else if (func == FN_CLOSE)
        begin
            if (one_per_line(closed_map | listed))
            begin
                closed_map = closed_map | listed;
                push_reply(ST_OK, 1'b0, 1'b1);
            end
            else
                push_reply(ST_CONFLICT, 1'b0, 1'b1);
        end
        else if (func == FN_OPEN)
        begin
            closed_map = closed_map & ~listed;
            push_reply(ST_OK, 1'b0, 1'b1);
        end
        else if (chan_cnt == 0)
            push_reply(ST_OK, 1'b0, 1'b1);
        else
            for (int i = 0; i < chan_cnt; i++)
            begin
                hit = closed_map[chan_buf[i]];
                push_reply(ST_OK, (func == FN_QUERY_CLOSED) ? hit : !hit, i == chan_cnt - 1);
            end
        chan_cnt   = 0;
        chan_fault = 0;
    endtask

    task automatic check_reply();
        reply_t want;
        if (reply_q.size() == 0)
        begin
            $error("result with nothing expected: status %0d drive %h", status, relay_drive);
            fail_count++;
            return;
        end
        want = reply_q.pop_front();
        checked++;
        if (status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
        end
        if (state_bit !== want.state_bit)
        begin
            $error("state_bit: expected %0d, got %0d", want.state_bit, state_bit);
            fail_count++;
        end
        if (relay_drive !== want.drive)
        begin
            $error("relay_drive: expected %h, got %h", want.drive, relay_drive);
            fail_count++;
        end
        if (last_res !== want.fin)
        begin
            $error("last_res: expected %0d, got %0d", want.fin, last_res);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_map = '0;
            chan_cnt   = 0;
            chan_fault = 0;
            reply_q.delete();
        end
        else
        begin
            if (done)
                check_reply();
            if (start && !busy)
                apply_entry();
        end
        pending = reply_q.size();
    end

endmodule

// ----- dv/crosspoint_relay_matrix_controller_tb.sv -----
// ----------------------------------------------------------------------------
// Crosspoint relay matrix controller testbench
// Drives channel-list entries into the controller: a directed set covering
// single channels, ranges in both directions, list overflow, index errors,
// conflicts, unused functions and every command, then random commands with
// random gaps. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module crosspoint_relay_matrix_controller_tb
    import crmc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FUNC_W-1:0] FN_RSVD_A = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSVD_B = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_C = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   func;
    logic [FIELD_W-1:0]  row_from;
    logic [FIELD_W-1:0]  col_from;
    logic [FIELD_W-1:0]  row_to;
    logic [FIELD_W-1:0]  col_to;
    logic                ranged;
    logic                has_column;
    logic                last;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic                state_bit;
    logic [DRIVE_W-1:0]  relay_drive;
    logic                last_res;

    int fail_count;
    int pending;
    int checked;
    int n_items;
    int n_cmds;
    bit quiet;

    crosspoint_relay_matrix_controller DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .row_from   (row_from),
        .col_from   (col_from),
        .row_to     (row_to),
        .col_to     (col_to),
        .ranged     (ranged),
        .has_column (has_column),
        .last       (last),
        .done       (done),
        .status     (status),
        .state_bit  (state_bit),
        .relay_drive(relay_drive),
        .last_res   (last_res)
    );

    crosspoint_relay_matrix_controller_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .row_from   (row_from),
        .col_from   (col_from),
        .row_to     (row_to),
        .col_to     (col_to),
        .ranged     (ranged),
        .has_column (has_column),
        .last       (last),
        .done       (done),
        .status     (status),
        .state_bit  (state_bit),
        .relay_drive(relay_drive),
        .last_res   (last_res),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("crosspoint_relay_matrix_controller_tb: errors");
        $finish;
    end

    task automatic idle_gap(int n);
        for (int k = 0; k < n; k++)
        begin
            @(negedge clk);
            start      = 1'b0;
            func       = FUNC_W'($urandom);
            row_from   = FIELD_W'($urandom);
            col_from   = FIELD_W'($urandom);
            row_to     = FIELD_W'($urandom);
            col_to     = FIELD_W'($urandom);
            ranged     = 1'($urandom);
            has_column = 1'($urandom);
            last       = 1'($urandom);
        end
    endtask

    task automatic send_entry(logic [FUNC_W-1:0] f, logic [FIELD_W-1:0] rf,
                              logic [FIELD_W-1:0] cf, logic [FIELD_W-1:0] rt,
                              logic [FIELD_W-1:0] ct, logic rng, logic hc, logic lst);
        @(negedge clk);
        func       = f;
        row_from   = rf;
        col_from   = cf;
        row_to     = rt;
        col_to     = ct;
        ranged     = rng;
        has_column = hc;
        last       = lst;
        start      = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_items++;
        if (!quiet && $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 3));
    endtask

    task automatic random_command();
        int                 n_ent;
        int                 pick;
        logic [FUNC_W-1:0]  f;
        logic [FIELD_W-1:0] rf, cf, rt, ct;
        logic               rng, hc;
        n_ent = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2);
        pick  = $urandom_range(0, 99);
        if (pick < 30)
            f = FN_CLOSE;
        else if (pick < 50)
            f = FN_OPEN;
        else if (pick < 65)
            f = FN_QUERY_CLOSED;
        else if (pick < 80)
            f = FN_QUERY_OPEN;
        else if (pick < 93)
            f = FN_OPEN_ALL;
        else
            f = FUNC_W'($urandom_range(FN_RSVD_A, FN_RSVD_C));
        for (int k = 0; k < n_ent; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                rf  = FIELD_W'($urandom);
                cf  = FIELD_W'($urandom);
                rt  = FIELD_W'($urandom);
                ct  = FIELD_W'($urandom);
                rng = 1'($urandom);
                hc  = 1'($urandom);
            end
            else
            begin
                rng = ($urandom_range(0, 2) == 0);
                hc  = ($urandom_range(0, 4) != 0);
                rf  = FIELD_W'($urandom_range(0, 3));
                cf  = hc ? FIELD_W'($urandom_range(0, 3)) : FIELD_W'($urandom);
                rt  = rng ? FIELD_W'($urandom_range(0, 3)) : FIELD_W'($urandom);
                ct  = (rng && hc) ? FIELD_W'($urandom_range(0, 3)) : FIELD_W'($urandom);
            end
            send_entry((k == n_ent - 1) ? f : FUNC_W'($urandom), rf, cf, rt, ct, rng, hc,
                       k == n_ent - 1);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        func       = '0;
        row_from   = '0;
        col_from   = '0;
        row_to     = '0;
        col_to     = '0;
        ranged     = 1'b0;
        has_column = 1'b0;
        last       = 1'b0;
        n_items    = 0;
        n_cmds     = 0;
        quiet      = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_entry(FN_CLOSE,        4'd0,  4'd0,  4'd15, 4'd15, 1'b0, 1'b1, 1'b1);
        send_entry(FN_QUERY_CLOSED, 4'd0,  4'd0,  4'd0,  4'd3,  1'b1, 1'b1, 1'b1);
        send_entry(FN_QUERY_OPEN,   4'd3,  4'd15, 4'd0,  4'd0,  1'b0, 1'b0, 1'b1);
        send_entry(FN_CLOSE,        4'd1,  4'd1,  4'd0,  4'd0,  1'b0, 1'b1, 1'b1);
        send_entry(FN_CLOSE,        4'd1,  4'd2,  4'd0,  4'd0,  1'b0, 1'b1, 1'b1);
        send_entry(FN_OPEN,         4'd2,  4'd2,  4'd0,  4'd0,  1'b0, 1'b1, 1'b0);
        send_entry(FN_CLOSE,        4'd3,  4'd3,  4'd0,  4'd0,  1'b0, 1'b1, 1'b1);
        send_entry(FN_QUERY_CLOSED, 4'd3,  4'd3,  4'd0,  4'd0,  1'b1, 1'b1, 1'b1);
        send_entry(FN_QUERY_OPEN,   4'd0,  4'd0,  4'd3,  4'd3,  1'b1, 1'b1, 1'b1);
        send_entry(FN_OPEN,         4'd0,  4'd0,  4'd1,  4'd3,  1'b1, 1'b1, 1'b1);
        send_entry(FN_CLOSE,        4'd4,  4'd0,  4'd0,  4'd0,  1'b0, 1'b1, 1'b1);
        send_entry(FN_QUERY_CLOSED, 4'd0,  4'd0,  4'd0,  4'd4,  1'b1, 1'b1, 1'b1);
        send_entry(FN_CLOSE,        4'd0,  4'd0,  4'd3,  4'd3,  1'b1, 1'b1, 1'b0);
        send_entry(FN_QUERY_OPEN,   4'd1,  4'd1,  4'd0,  4'd0,  1'b0, 1'b1, 1'b1);
        send_entry(FN_QUERY_CLOSED, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1, 1'b1, 1'b0);
        send_entry(FN_OPEN_ALL,     4'd0,  4'd0,  4'd0,  4'd0,  1'b0, 1'b1, 1'b1);
        send_entry(FN_RSVD_A,       4'd1,  4'd1,  4'd0,  4'd0,  1'b0, 1'b1, 1'b1);
        send_entry(FN_RSVD_B,       4'd2,  4'd0,  4'd0,  4'd0,  1'b0, 1'b0, 1'b1);
        send_entry(FN_RSVD_C,       4'd3,  4'd3,  4'd0,  4'd0,  1'b0, 1'b1, 1'b1);
        send_entry(FN_CLOSE,        4'd0,  4'd9,  4'd3,  4'd9,  1'b1, 1'b0, 1'b1);
        send_entry(FN_CLOSE,        4'd2,  4'd3,  4'd2,  4'd0,  1'b1, 1'b1, 1'b1);
        send_entry(FN_CLOSE,        4'd2,  4'd1,  4'd0,  4'd0,  1'b0, 1'b1, 1'b1);
        send_entry(FN_QUERY_OPEN,   4'd2,  4'd3,  4'd2,  4'd0,  1'b1, 1'b1, 1'b1);
        n_cmds = 20;

        while (n_items < 300)
        begin
            quiet = (n_items >= 250);
            random_command();
            n_cmds++;
        end
        @(negedge clk);
        start = 1'b0;

        for (int guard = 0; pending != 0 && guard < 5000; guard++)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (pending != 0)
            $error("%0d expected results never arrived", pending);

        $display("%0d list entries in %0d commands sent, %0d results compared",
                 n_items, n_cmds, checked);
        $display("covered: ranges both ways, overflow, index errors, conflicts, all functions");
        if (fail_count == 0 && pending == 0)
            $display("crosspoint_relay_matrix_controller_tb: clean");
        else
            $display("crosspoint_relay_matrix_controller_tb: errors");
        $finish;
    end

endmodule

// ----- crosspoint_relay_matrix_controller.f -----
+incdir+rtl
rtl/crmc_pkg.sv
rtl/crmc_ram.sv
rtl/crosspoint_relay_matrix_controller.sv
rtl/crmc_checker.sv
dv/crosspoint_relay_matrix_controller_checker.sv
dv/crosspoint_relay_matrix_controller_tb.sv
